### hdl/mbrs_pkg.sv
// ---------------------------------------------------------------------------
// mbrs_pkg: shared types and constants of the Modbus register server
// Function codes, exception codes, controller command and status bundles,
// and the address window check.
// ---------------------------------------------------------------------------
package mbrs_pkg;

    // Default sizes
    localparam int HOLD_DEPTH_DEF  = 256;
    localparam int INPUT_DEPTH_DEF = 256;
    localparam int PDU_MAX_DEF     = 256;

    // Request buffer and captured header
    localparam int BUF_DEPTH = 256;
    localparam int HDR_LEN   = 10;

    // Item operations
    localparam logic [1:0] OP_REQ  = 2'd0;
    localparam logic [1:0] OP_PULL = 2'd1;
    localparam logic [1:0] OP_LOAD = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_HOLD_BASE  = 2'd0;
    localparam logic [1:0] REG_HOLD_COUNT = 2'd1;
    localparam logic [1:0] REG_IN_BASE    = 2'd2;
    localparam logic [1:0] REG_IN_COUNT   = 2'd3;

    // Status / exception codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ILL_FUNC = 2'd1;
    localparam logic [1:0] ST_ILL_VAL  = 2'd2;
    localparam logic [1:0] ST_ILL_ADDR = 2'd3;

    // Function codes
    localparam logic [7:0] FC_RD_HOLD  = 8'd3;
    localparam logic [7:0] FC_RD_INPUT = 8'd4;
    localparam logic [7:0] FC_WR_ONE   = 8'd6;
    localparam logic [7:0] FC_WR_MULTI = 8'd16;
    localparam logic [7:0] FC_RW_MULTI = 8'd23;
    localparam logic [7:0] EXC_FLAG    = 8'h80;

    // Count limits of the standard
    localparam logic [15:0] RD_MAX    = 16'd125;
    localparam logic [15:0] WR_MAX    = 16'd123;
    localparam logic [15:0] RW_WR_MAX = 16'd121;

    // Maximum response length
    localparam logic [8:0] RESP_MAX = 9'd252;

    // Datapath step selected by the controller
    typedef enum logic [3:0] {
        STEP_IDLE,
        STEP_CLEAR,
        STEP_CHECK,
        STEP_DISPATCH,
        STEP_WR_HI,
        STEP_WR_LO,
        STEP_WR_PUT,
        STEP_RD_CNT,
        STEP_RD_GET,
        STEP_RD_HI,
        STEP_RD_LO,
        STEP_EXC_FC,
        STEP_EXC_ST,
        STEP_FINISH,
        STEP_EMIT_REQ,
        STEP_EMIT_PULL
    } step_t;

    typedef struct packed {
        logic  accept;
        logic  load;
        step_t step;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic pull_pend;
        logic wr_go;
        logic wr_last;
        logic rd_go;
        logic rd_last;
        logic exc;
    } sts_t;

    // True when addr .. addr+num-1 lies inside base .. base+min(cnt,depth)-1
    function automatic logic mbrs_in_window(input logic [15:0] addr,
                                            input logic [15:0] num,
                                            input logic [15:0] base,
                                            input logic [8:0]  cnt,
                                            input logic [16:0] depth);
        logic [16:0] w;
        logic [17:0] hi_req;
        logic [17:0] hi_lim;
        w      = ({8'd0, cnt} < depth) ? {8'd0, cnt} : depth;
        hi_req = {2'b00, addr} + {2'b00, num};
        hi_lim = {2'b00, base} + {1'b0, w};
        return (addr >= base) && (hi_req <= hi_lim);
    endfunction

endpackage

### hdl/modbus_register_server.sv
// ---------------------------------------------------------------------------
// modbus_register_server: Modbus holding/input register server
// Serves function codes 3, 4, 6, 16 and 23 on a PDU byte stream, with a
// local load port for the input registers.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_ready   op, pdu_byte, pdu_last, load_index,
//                                  load_value
//   out      out_valid / out_ready status, resp_length, resp_byte, resp_last
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A response byte pull goes through EMIT_PULL. A completed request goes
// through CHECK and DISPATCH, WR_HI, WR_LO and WR_PUT per register written,
// RD_CNT or RD_GET, RD_HI and RD_LO per register read, then FINISH and
// EMIT_REQ. After reset the stores are cleared one entry a cycle, over the
// larger of HOLD_DEPTH and INPUT_DEPTH entries; no item is taken meanwhile.
// A result waits in the output register while out_ready is low; the next
// item is taken meanwhile. Configuration is taken in every cycle.
// ---------------------------------------------------------------------------
module modbus_register_server
#(
    parameter int HOLD_DEPTH  = mbrs_pkg::HOLD_DEPTH_DEF,
    parameter int INPUT_DEPTH = mbrs_pkg::INPUT_DEPTH_DEF,
    parameter int PDU_MAX     = mbrs_pkg::PDU_MAX_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  pdu_byte,
    input  logic        pdu_last,
    input  logic [7:0]  load_index,
    input  logic [15:0] load_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [8:0]  resp_length,
    output logic [7:0]  resp_byte,
    output logic        resp_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import mbrs_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Accept configuration in every cycle
    assign cfg_ready = 1'b1;

    mbrs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .pdu_last  (pdu_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    mbrs_dp
    #(
        .HOLD_DEPTH  (HOLD_DEPTH),
        .INPUT_DEPTH (INPUT_DEPTH),
        .PDU_MAX     (PDU_MAX)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .op          (op),
        .pdu_byte    (pdu_byte),
        .load_index  (load_index),
        .load_value  (load_value),
        .status      (status),
        .resp_length (resp_length),
        .resp_byte   (resp_byte),
        .resp_last   (resp_last)
    );

endmodule

### hdl/mbrs_ctrl.sv
// ---------------------------------------------------------------------------
// mbrs_ctrl: sequencing controller
// Steps the datapath through store clearing, request checking, register
// write and read loops, exception build and result transfer.
// ---------------------------------------------------------------------------
module mbrs_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    op,
    input  logic          pdu_last,
    output logic          out_valid,
    input  logic          out_ready,
    output mbrs_pkg::cmd_t cmd,
    input  mbrs_pkg::sts_t sts
);
    import mbrs_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_DISPATCH,
        S_WR_HI,
        S_WR_LO,
        S_WR_PUT,
        S_RD_CNT,
        S_RD_GET,
        S_RD_HI,
        S_RD_LO,
        S_EXC_FC,
        S_EXC_ST,
        S_FINISH,
        S_EMIT_REQ,
        S_EMIT_PULL
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   load;
    logic   emit;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && (state_reg == S_IDLE);
    assign emit      = (state_reg == S_EMIT_REQ) || (state_reg == S_EMIT_PULL);
    assign load      = emit && (!out_valid_reg || out_ready);

    // Pick the next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_REQ && pdu_last)
                        state_next = S_CHECK;
                    else if (op == OP_PULL && sts.pull_pend)
                        state_next = S_EMIT_PULL;
                end
            end
            S_CHECK:    state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                if (sts.wr_go)
                    state_next = S_WR_HI;
                else if (sts.rd_go)
                    state_next = S_RD_CNT;
                else if (sts.exc)
                    state_next = S_EXC_FC;
                else
                    state_next = S_FINISH;
            end
            S_WR_HI:    state_next = S_WR_LO;
            S_WR_LO:    state_next = S_WR_PUT;
            S_WR_PUT:
            begin
                if (!sts.wr_last)
                    state_next = S_WR_HI;
                else if (sts.rd_go)
                    state_next = S_RD_CNT;
                else if (sts.exc)
                    state_next = S_EXC_FC;
                else
                    state_next = S_FINISH;
            end
            S_RD_CNT:   state_next = S_RD_HI;
            S_RD_GET:   state_next = S_RD_HI;
            S_RD_HI:    state_next = S_RD_LO;
            S_RD_LO:    state_next = sts.rd_last ? S_FINISH : S_RD_GET;
            S_EXC_FC:   state_next = S_EXC_ST;
            S_EXC_ST:   state_next = S_FINISH;
            S_FINISH:   state_next = S_EMIT_REQ;
            S_EMIT_REQ,
            S_EMIT_PULL:
            begin
                if (load)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Hold the result valid until transfer
    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Map the state onto a datapath step
    always_comb
    begin
        cmd.accept = accept;
        cmd.load   = load;
        case (state_reg)
            S_CLEAR:     cmd.step = STEP_CLEAR;
            S_IDLE:      cmd.step = STEP_IDLE;
            S_CHECK:     cmd.step = STEP_CHECK;
            S_DISPATCH:  cmd.step = STEP_DISPATCH;
            S_WR_HI:     cmd.step = STEP_WR_HI;
            S_WR_LO:     cmd.step = STEP_WR_LO;
            S_WR_PUT:    cmd.step = STEP_WR_PUT;
            S_RD_CNT:    cmd.step = STEP_RD_CNT;
            S_RD_GET:    cmd.step = STEP_RD_GET;
            S_RD_HI:     cmd.step = STEP_RD_HI;
            S_RD_LO:     cmd.step = STEP_RD_LO;
            S_EXC_FC:    cmd.step = STEP_EXC_FC;
            S_EXC_ST:    cmd.step = STEP_EXC_ST;
            S_FINISH:    cmd.step = STEP_FINISH;
            S_EMIT_REQ:  cmd.step = STEP_EMIT_REQ;
            S_EMIT_PULL: cmd.step = STEP_EMIT_PULL;
            default:     cmd.step = STEP_IDLE;
        endcase
    end

endmodule

### hdl/mbrs_dp.sv
// ---------------------------------------------------------------------------
// mbrs_dp: Modbus register server datapath
// Configuration registers, request buffer, holding and input stores,
// request check, register move counters and the result register.
// ---------------------------------------------------------------------------
module mbrs_dp
#(
    parameter int HOLD_DEPTH  = mbrs_pkg::HOLD_DEPTH_DEF,
    parameter int INPUT_DEPTH = mbrs_pkg::INPUT_DEPTH_DEF,
    parameter int PDU_MAX     = mbrs_pkg::PDU_MAX_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  mbrs_pkg::cmd_t cmd,
    output mbrs_pkg::sts_t sts,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [15:0]    cfg_data,
    input  logic [1:0]     op,
    input  logic [7:0]     pdu_byte,
    input  logic [7:0]     load_index,
    input  logic [15:0]    load_value,
    output logic [1:0]     status,
    output logic [8:0]     resp_length,
    output logic [7:0]     resp_byte,
    output logic           resp_last
);
    import mbrs_pkg::*;

    localparam int HOLD_AW   = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int IN_AW     = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
    localparam int CLR_DEPTH = (HOLD_DEPTH > INPUT_DEPTH) ? HOLD_DEPTH : INPUT_DEPTH;
    localparam logic [16:0] CLR_LAST = 17'(CLR_DEPTH - 1);
    localparam logic [16:0] HOLD_LIM = 17'(HOLD_DEPTH);
    localparam logic [16:0] IN_LIM   = 17'(INPUT_DEPTH);
    localparam logic [8:0]  PDU_LIM  = 9'(PDU_MAX);
    localparam logic [8:0]  HDR_LIM  = 9'(HDR_LEN);

    // Configuration
    logic [15:0] hold_base_reg;
    logic [8:0]  hold_cnt_reg;
    logic [15:0] in_base_reg;
    logic [8:0]  in_cnt_reg;

    // Control state
    logic [8:0]  req_len_reg;
    logic [8:0]  resp_ptr_reg;
    logic [8:0]  resp_len_reg;
    logic [16:0] clr_idx_reg;

    // Captured header and plan
    logic [7:0]  hdr_reg [HDR_LEN];
    logic [1:0]  st_reg;
    logic [8:0]  len_reg;
    logic        wr_go_reg;
    logic [6:0]  wr_cnt_reg;
    logic [7:0]  wr_src_reg;
    logic [15:0] wr_idx_reg;
    logic [7:0]  wr_hi_reg;
    logic        rd_go_reg;
    logic        rd_sel_reg;
    logic [6:0]  rd_cnt_reg;
    logic [15:0] rd_idx_reg;
    logic [7:0]  rd_dst_reg;

    // Memories
    logic [7:0]  buf_mem  [BUF_DEPTH];
    logic [15:0] hold_mem [HOLD_DEPTH];
    logic [15:0] in_mem   [INPUT_DEPTH];
    logic [7:0]  buf_q;
    logic [15:0] hold_q;
    logic [15:0] in_q;
    logic [15:0] store_q;

    logic               buf_we;
    logic [7:0]         buf_waddr;
    logic [7:0]         buf_wdata;
    logic [7:0]         buf_raddr;
    logic               hold_we;
    logic [HOLD_AW-1:0] hold_waddr;
    logic [15:0]        hold_wdata;
    logic               in_we;
    logic [IN_AW-1:0]   in_waddr;
    logic [15:0]        in_wdata;
    logic [16:0]        load_ext;

    logic req_take;
    logic load_take;

    // Request fields
    logic [7:0]  fc;
    logic [15:0] a1, n1, a2, n2;
    logic [7:0]  bc16, bc23;
    logic        win_rh, win_ri, win_w1, win_w16, win_w23;

    // Check results
    logic [1:0]  c_st;
    logic [8:0]  c_len;
    logic        c_wr;
    logic [6:0]  c_wr_n;
    logic [7:0]  c_wr_src;
    logic [15:0] c_wr_first;
    logic        c_rd;
    logic        c_rd_sel;
    logic [15:0] c_rd_first;

    assign req_take  = cmd.accept && (op == OP_REQ);
    assign load_take = cmd.accept && (op == OP_LOAD);
    assign load_ext  = {9'd0, load_index};

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_base_reg <= '0;
            hold_cnt_reg  <= '0;
            in_base_reg   <= '0;
            in_cnt_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HOLD_BASE:  hold_base_reg <= cfg_data;
                REG_HOLD_COUNT: hold_cnt_reg  <= cfg_data[8:0];
                REG_IN_BASE:    in_base_reg   <= cfg_data;
                REG_IN_COUNT:   in_cnt_reg    <= cfg_data[8:0];
                default:        hold_base_reg <= hold_base_reg;
            endcase
        end
    end

    // Request length, response pointer and clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_len_reg  <= '0;
            resp_ptr_reg <= '0;
            resp_len_reg <= '0;
            clr_idx_reg  <= '0;
        end
        else
        begin
            if (cmd.step == STEP_CLEAR && clr_idx_reg != CLR_LAST)
                clr_idx_reg <= clr_idx_reg + 17'd1;
            if (req_take)
            begin
                resp_ptr_reg <= '0;
                resp_len_reg <= '0;
                if (req_len_reg < PDU_LIM)
                    req_len_reg <= req_len_reg + 9'd1;
            end
            else if (cmd.step == STEP_FINISH)
            begin
                req_len_reg  <= '0;
                resp_len_reg <= len_reg;
            end
            else if (cmd.load && cmd.step == STEP_EMIT_PULL)
            begin
                resp_ptr_reg <= resp_ptr_reg + 9'd1;
            end
        end
    end

    // Capture header bytes as they arrive
    always_ff @(posedge clk)
    begin
        if (req_take && req_len_reg < HDR_LIM)
            hdr_reg[req_len_reg[3:0]] <= pdu_byte;
    end

    assign fc   = hdr_reg[0];
    assign a1   = {hdr_reg[1], hdr_reg[2]};
    assign n1   = {hdr_reg[3], hdr_reg[4]};
    assign a2   = {hdr_reg[5], hdr_reg[6]};
    assign n2   = {hdr_reg[7], hdr_reg[8]};
    assign bc16 = hdr_reg[5];
    assign bc23 = hdr_reg[9];

    assign win_rh  = mbrs_in_window(a1, n1, hold_base_reg, hold_cnt_reg, HOLD_LIM);
    assign win_ri  = mbrs_in_window(a1, n1, in_base_reg, in_cnt_reg, IN_LIM);
    assign win_w1  = mbrs_in_window(a1, 16'd1, hold_base_reg, hold_cnt_reg, HOLD_LIM);
    assign win_w16 = win_rh;
    assign win_w23 = mbrs_in_window(a2, n2, hold_base_reg, hold_cnt_reg, HOLD_LIM);

    // Check the completed request and plan the register moves
    always_comb
    begin
        c_st       = ST_OK;
        c_wr       = 1'b0;
        c_wr_n     = 7'd1;
        c_wr_src   = 8'd3;
        c_wr_first = a1 - hold_base_reg;
        c_rd       = 1'b0;
        c_rd_sel   = 1'b0;
        c_rd_first = a1 - hold_base_reg;
        c_len      = 9'd2 + {1'b0, n1[6:0], 1'b0};
        case (fc)
            FC_RD_HOLD,
            FC_RD_INPUT:
            begin
                c_rd_sel = (fc == FC_RD_INPUT);
                if (fc == FC_RD_INPUT)
                    c_rd_first = a1 - in_base_reg;
                if (req_len_reg != 9'd5 || n1 == 16'd0 || n1 > RD_MAX)
                    c_st = ST_ILL_VAL;
                else if ((fc == FC_RD_HOLD) ? !win_rh : !win_ri)
                    c_st = ST_ILL_ADDR;
                else
                    c_rd = 1'b1;
            end
            FC_WR_ONE:
            begin
                c_len = 9'd5;
                if (req_len_reg != 9'd5)
                    c_st = ST_ILL_VAL;
                else if (!win_w1)
                    c_st = ST_ILL_ADDR;
                else
                    c_wr = 1'b1;
            end
            FC_WR_MULTI:
            begin
                c_len    = 9'd5;
                c_wr_n   = n1[6:0];
                c_wr_src = 8'd6;
                if (req_len_reg < 9'd6 || n1 == 16'd0 || n1 > WR_MAX
                    || bc16 != {n1[6:0], 1'b0}
                    || req_len_reg != 9'd6 + {1'b0, bc16})
                    c_st = ST_ILL_VAL;
                else if (!win_w16)
                    c_st = ST_ILL_ADDR;
                else
                    c_wr = 1'b1;
            end
            FC_RW_MULTI:
            begin
                c_wr_n     = n2[6:0];
                c_wr_src   = 8'd10;
                c_wr_first = a2 - hold_base_reg;
                if (req_len_reg < 9'd10 || n1 == 16'd0 || n1 > RD_MAX
                    || n2 == 16'd0 || n2 > RW_WR_MAX
                    || bc23 != {n2[6:0], 1'b0}
                    || req_len_reg != 9'd10 + {1'b0, bc23})
                    c_st = ST_ILL_VAL;
                else if (!win_w23)
                    c_st = ST_ILL_ADDR;
                else
                begin
                    c_wr = 1'b1;
                    if (!win_rh)
                        c_st = ST_ILL_ADDR;
                    else
                        c_rd = 1'b1;
                end
            end
            default:
            begin
                c_st = ST_ILL_FUNC;
            end
        endcase
        if (c_st != ST_OK)
            c_len = 9'd2;
    end

    // Plan registers and move counters
    always_ff @(posedge clk)
    begin
        case (cmd.step)
            STEP_CHECK:
            begin
                st_reg     <= c_st;
                len_reg    <= c_len;
                wr_go_reg  <= c_wr;
                wr_cnt_reg <= c_wr_n;
                wr_src_reg <= c_wr_src;
                wr_idx_reg <= c_wr_first;
                rd_go_reg  <= c_rd;
                rd_sel_reg <= c_rd_sel;
                rd_cnt_reg <= n1[6:0];
                rd_idx_reg <= c_rd_first;
                rd_dst_reg <= 8'd2;
            end
            STEP_WR_LO:
            begin
                wr_hi_reg <= buf_q;
            end
            STEP_WR_PUT:
            begin
                wr_src_reg <= wr_src_reg + 8'd2;
                wr_idx_reg <= wr_idx_reg + 16'd1;
                wr_cnt_reg <= wr_cnt_reg - 7'd1;
            end
            STEP_RD_LO:
            begin
                rd_dst_reg <= rd_dst_reg + 8'd2;
                rd_idx_reg <= rd_idx_reg + 16'd1;
                rd_cnt_reg <= rd_cnt_reg - 7'd1;
            end
            default:
            begin
                wr_hi_reg <= wr_hi_reg;
            end
        endcase
    end

    assign store_q = rd_sel_reg ? in_q : hold_q;

    // Request buffer port selection
    always_comb
    begin
        buf_we    = 1'b0;
        buf_waddr = req_len_reg[7:0];
        buf_wdata = pdu_byte;
        buf_raddr = resp_ptr_reg[7:0];
        case (cmd.step)
            STEP_IDLE:
            begin
                buf_we = req_take && (req_len_reg < PDU_LIM);
            end
            STEP_WR_HI:
            begin
                buf_raddr = wr_src_reg;
            end
            STEP_WR_LO:
            begin
                buf_raddr = wr_src_reg + 8'd1;
            end
            STEP_RD_CNT:
            begin
                buf_we    = 1'b1;
                buf_waddr = 8'd1;
                buf_wdata = {rd_cnt_reg, 1'b0};
            end
            STEP_RD_HI:
            begin
                buf_we    = 1'b1;
                buf_waddr = rd_dst_reg;
                buf_wdata = store_q[15:8];
            end
            STEP_RD_LO:
            begin
                buf_we    = 1'b1;
                buf_waddr = rd_dst_reg + 8'd1;
                buf_wdata = store_q[7:0];
            end
            STEP_EXC_FC:
            begin
                buf_we    = 1'b1;
                buf_waddr = 8'd0;
                buf_wdata = fc | EXC_FLAG;
            end
            STEP_EXC_ST:
            begin
                buf_we    = 1'b1;
                buf_waddr = 8'd1;
                buf_wdata = {6'd0, st_reg};
            end
            default:
            begin
                buf_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
            buf_mem[buf_waddr] <= buf_wdata;
        buf_q <= buf_mem[buf_raddr];
    end

    // Holding store: clearing sweep or register write
    always_comb
    begin
        if (cmd.step == STEP_CLEAR)
        begin
            hold_we    = (clr_idx_reg < HOLD_LIM);
            hold_waddr = clr_idx_reg[HOLD_AW-1:0];
            hold_wdata = '0;
        end
        else
        begin
            hold_we    = (cmd.step == STEP_WR_PUT);
            hold_waddr = wr_idx_reg[HOLD_AW-1:0];
            hold_wdata = {wr_hi_reg, buf_q};
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold_we)
            hold_mem[hold_waddr] <= hold_wdata;
        hold_q <= hold_mem[rd_idx_reg[HOLD_AW-1:0]];
    end

    // Input store: clearing sweep or local load
    always_comb
    begin
        if (cmd.step == STEP_CLEAR)
        begin
            in_we    = (clr_idx_reg < IN_LIM);
            in_waddr = clr_idx_reg[IN_AW-1:0];
            in_wdata = '0;
        end
        else
        begin
            in_we    = load_take && (load_ext < IN_LIM);
            in_waddr = load_ext[IN_AW-1:0];
            in_wdata = load_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_we)
            in_mem[in_waddr] <= in_wdata;
        in_q <= in_mem[rd_idx_reg[IN_AW-1:0]];
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (cmd.step == STEP_EMIT_PULL)
            begin
                status      <= ST_OK;
                resp_length <= resp_len_reg;
                resp_byte   <= buf_q;
                resp_last   <= (resp_ptr_reg + 9'd1 == resp_len_reg);
            end
            else
            begin
                status      <= st_reg;
                resp_length <= len_reg;
                resp_byte   <= 8'd0;
                resp_last   <= 1'b0;
            end
        end
    end

    // Status to the controller
    assign sts.clear_done = (clr_idx_reg == CLR_LAST);
    assign sts.pull_pend  = (resp_ptr_reg < resp_len_reg);
    assign sts.wr_go      = wr_go_reg;
    assign sts.wr_last    = (wr_cnt_reg == 7'd1);
    assign sts.rd_go      = rd_go_reg;
    assign sts.rd_last    = (rd_cnt_reg == 7'd1);
    assign sts.exc        = (st_reg != ST_OK);

endmodule

### hdl/mbrs_checker.sv
// ---------------------------------------------------------------------------
// mbrs_checker: port-level checks of the Modbus register server
// Watches the result channel for stall stability and response consistency.
// ---------------------------------------------------------------------------
module mbrs_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic [8:0] resp_length,
    input logic [7:0] resp_byte,
    input logic       resp_last
);
    import mbrs_pkg::*;

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(resp_length) && $stable(resp_byte) && $stable(resp_last))
        else $error("stalled result changed");

    // Exception responses are two bytes
    a_exc_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> resp_length == 9'd2 && !resp_last)
        else $error("exception with wrong length");

    // Final byte only on a pull with data
    a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && resp_last |-> status == ST_OK && resp_length != 9'd0)
        else $error("final byte with bad status or length");

    // Response never exceeds the largest read
    a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> resp_length <= RESP_MAX)
        else $error("response length out of range");

endmodule

bind modbus_register_server mbrs_checker u_mbrs_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .resp_length (resp_length),
    .resp_byte   (resp_byte),
    .resp_last   (resp_last)
);

### verif/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the Modbus register server
// Streams request PDUs for function codes 3, 4, 6, 16 and 23 (well-formed
// and broken), response pulls and local input loads through several window
// settings. Every result is checked field by field against an in-bench model
// of the server, with random idle bursts on both channels.
// ---------------------------------------------------------------------------
module tb_top;
    import mbrs_pkg::*;

    localparam logic [1:0] OP_IGNORED = 2'd3;
    localparam int DRAIN_CYCLES = 1000;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int PHASE_ITEMS  = 110;

    typedef struct {
        logic [1:0]  op;
        logic [7:0]  pbyte;
        logic        plast;
        logic [7:0]  lidx;
        logic [15:0] lval;
    } item_t;

    typedef struct {
        logic [1:0] st;
        logic [8:0] len;
        logic [7:0] rbyte;
        logic       rlast;
    } resp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  op = OP_IGNORED;
    logic [7:0]  pdu_byte = '0;
    logic        pdu_last = 1'b0;
    logic [7:0]  load_index = '0;
    logic [15:0] load_value = '0;
    logic        out_valid;
    logic        out_ready = 1'b1;
    logic [1:0]  status;
    logic [8:0]  resp_length;
    logic [7:0]  resp_byte;
    logic        resp_last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    modbus_register_server u_dut (.*);

    // Server image kept by the bench
    logic [7:0]  pdu_buf [256];
    logic [15:0] hold_regs [256];
    logic [15:0] input_regs [256];
    int unsigned pdu_len;
    int unsigned pull_ptr;
    int unsigned resp_held;
    int unsigned hold_base, hold_cnt, in_base, in_cnt;

    item_t       item_q[$];
    resp_t       resp_q[$];
    item_t       cur_item;
    int unsigned pushed;
    int unsigned errors;
    int unsigned cycles;
    int unsigned in_gap;
    int unsigned out_stall;
    bit          quiet;

    always #5 clk = ~clk;

    initial
    begin
        foreach (pdu_buf[i])
        begin
            pdu_buf[i] = '0;
            hold_regs[i] = '0;
            input_regs[i] = '0;
        end
        pdu_len = 0; pull_ptr = 0; resp_held = 0;
        hold_base = 0; hold_cnt = 0; in_base = 0; in_cnt = 0;
        pushed = 0; errors = 0; cycles = 0; in_gap = 0; out_stall = 0; quiet = 0;
    end

    // ---------------- server model ----------------
    function automatic int unsigned word_at(int unsigned i);
        return 32'({pdu_buf[i & 255], pdu_buf[(i + 1) & 255]});
    endfunction

    function automatic bit fits(int unsigned a, int unsigned n, int unsigned base,
                                int unsigned cnt);
        int unsigned w;
        w = (cnt < 256) ? cnt : 256;
        return (a >= base) && (a + n <= base + w);
    endfunction

    function automatic void fill_regs(bit from_hold, int unsigned first, int unsigned n);
        logic [15:0] v;
        pdu_buf[1] = 8'((2 * n) & 255);
        for (int unsigned i = 0; i < n; i++)
        begin
            v = from_hold ? hold_regs[first + i] : input_regs[first + i];
            pdu_buf[(2 + 2 * i) & 255] = v[15:8];
            pdu_buf[(3 + 2 * i) & 255] = v[7:0];
        end
    endfunction

    function automatic void store_regs(int unsigned first, int unsigned n, int unsigned src);
        for (int unsigned i = 0; i < n; i++)
            hold_regs[first + i] = 16'(word_at(src + 2 * i));
    endfunction

    function automatic void serve_request(output logic [1:0] st, output int unsigned len);
        int unsigned fc, a, n, ra, rn, bc;
        fc = 32'(pdu_buf[0]);
        st = ST_OK;
        len = 0;
        case (fc)
            FC_RD_HOLD, FC_RD_INPUT:
            begin
                a = word_at(1); n = word_at(3);
                if (pdu_len != 5 || n < 1 || n > RD_MAX)
                    st = ST_ILL_VAL;
                else if (fc == FC_RD_HOLD && !fits(a, n, hold_base, hold_cnt))
                    st = ST_ILL_ADDR;
                else if (fc == FC_RD_INPUT && !fits(a, n, in_base, in_cnt))
                    st = ST_ILL_ADDR;
                else
                begin
                    if (fc == FC_RD_HOLD)
                        fill_regs(1'b1, a - hold_base, n);
                    else
                        fill_regs(1'b0, a - in_base, n);
                    len = 2 + 2 * n;
                end
            end
            FC_WR_ONE:
            begin
                a = word_at(1);
                if (pdu_len != 5)
                    st = ST_ILL_VAL;
                else if (!fits(a, 1, hold_base, hold_cnt))
                    st = ST_ILL_ADDR;
                else
                begin
                    store_regs(a - hold_base, 1, 3);
                    len = 5;
                end
            end
            FC_WR_MULTI:
            begin
                a = word_at(1); n = word_at(3); bc = 32'(pdu_buf[5]);
                if (pdu_len < 6 || n < 1 || n > WR_MAX || bc != 2 * n || pdu_len != 6 + bc)
                    st = ST_ILL_VAL;
                else if (!fits(a, n, hold_base, hold_cnt))
                    st = ST_ILL_ADDR;
                else
                begin
                    store_regs(a - hold_base, n, 6);
                    len = 5;
                end
            end
            FC_RW_MULTI:
            begin
                ra = word_at(1); rn = word_at(3); a = word_at(5); n = word_at(7);
                bc = 32'(pdu_buf[9]);
                if (pdu_len < 10 || rn < 1 || rn > RD_MAX || n < 1 || n > RW_WR_MAX ||
                    bc != 2 * n || pdu_len != 10 + bc)
                    st = ST_ILL_VAL;
                else if (!fits(a, n, hold_base, hold_cnt))
                    st = ST_ILL_ADDR;
                else
                begin
                    // write part stays even when the read part fails
                    store_regs(a - hold_base, n, 10);
                    if (!fits(ra, rn, hold_base, hold_cnt))
                        st = ST_ILL_ADDR;
                    else
                    begin
                        fill_regs(1'b1, ra - hold_base, rn);
                        len = 2 + 2 * rn;
                    end
                end
            end
            default: st = ST_ILL_FUNC;
        endcase
        if (st != ST_OK)
        begin
            pdu_buf[0] = 8'(fc) | EXC_FLAG;
            pdu_buf[1] = {6'd0, st};
            len = 2;
        end
    endfunction

    function automatic void predict_item(item_t it);
        resp_t r;
        logic [1:0] st;
        int unsigned len;
        case (it.op)
            OP_REQ:
            begin
                // a new request byte cancels any unpulled response
                pull_ptr = 0;
                resp_held = 0;
                if (pdu_len < 256)
                begin
                    pdu_buf[pdu_len] = it.pbyte;
                    pdu_len++;
                end
                if (it.plast)
                begin
                    serve_request(st, len);
                    pdu_len = 0;
                    resp_held = len & 511;
                    r.st = st; r.len = 9'(len); r.rbyte = '0; r.rlast = 1'b0;
                    resp_q.push_back(r);
                end
            end
            OP_PULL:
            begin
                if (pull_ptr < resp_held && pull_ptr < 256)
                begin
                    r.st = ST_OK; r.len = 9'(resp_held); r.rbyte = pdu_buf[pull_ptr];
                    r.rlast = (pull_ptr + 1 == resp_held);
                    resp_q.push_back(r);
                    pull_ptr++;
                end
            end
            OP_LOAD: input_regs[it.lidx] = it.lval;
            default: ;
        endcase
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic void push_item(logic [1:0] o, logic [7:0] b, logic l,
                                      logic [7:0] idx, logic [15:0] v);
        item_t it;
        it.op = o; it.pbyte = b; it.plast = l; it.lidx = idx; it.lval = v;
        item_q.push_back(it);
        if (o != OP_IGNORED)
            pushed++;
    endfunction

    function automatic void push_pulls(int unsigned n);
        repeat (n)
            push_item(OP_PULL, 8'($urandom), 1'($urandom), 8'($urandom), 16'($urandom));
    endfunction

    function automatic void push_pdu(logic [7:0] q[$]);
        foreach (q[i])
            push_item(OP_REQ, q[i], i == q.size() - 1, 8'($urandom), 16'($urandom));
    endfunction

    function automatic int unsigned pick_count(int unsigned lim, int unsigned w);
        int unsigned top;
        top = (w < 1) ? 1 : w;
        if (top > lim)
            top = lim;
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(1, top);
        return $urandom_range(1, (top > 8) ? 8 : top);
    endfunction

    function automatic logic [15:0] pick_addr(int unsigned base, int unsigned cnt,
                                              int unsigned n);
        int unsigned w, r;
        w = (cnt < 256) ? cnt : 256;
        r = $urandom_range(0, 9);
        if (r < 8)
            return 16'(base + $urandom_range(0, (w >= n) ? w - n : 0));
        if (r == 8)
            return 16'(base + w - n + 1);
        return 16'($urandom);
    endfunction

    // Build one request of the given function code, optionally broken
    function automatic void gen_request(logic [7:0] fc, bit broken);
        logic [7:0]  q[$];
        logic [15:0] a, n, ra, rn, v;
        int unsigned plen;
        q = {fc};
        plen = 5;
        case (fc)
            FC_RD_HOLD, FC_RD_INPUT:
            begin
                n = 16'(pick_count(RD_MAX, (fc == FC_RD_HOLD) ? hold_cnt : in_cnt));
                a = (fc == FC_RD_HOLD) ? pick_addr(hold_base, hold_cnt, n)
                                       : pick_addr(in_base, in_cnt, n);
                q = {q, a[15:8], a[7:0], n[15:8], n[7:0]};
                plen = 2 + 2 * n;
            end
            FC_WR_ONE:
            begin
                a = pick_addr(hold_base, hold_cnt, 1);
                v = 16'($urandom);
                q = {q, a[15:8], a[7:0], v[15:8], v[7:0]};
            end
            FC_WR_MULTI:
            begin
                n = 16'(pick_count(WR_MAX, hold_cnt));
                a = pick_addr(hold_base, hold_cnt, n);
                q = {q, a[15:8], a[7:0], n[15:8], n[7:0], 8'(2 * n)};
                repeat (2 * n) q.push_back(8'($urandom));
            end
            FC_RW_MULTI:
            begin
                rn = 16'(pick_count(RD_MAX, hold_cnt));
                ra = pick_addr(hold_base, hold_cnt, rn);
                n = 16'(pick_count(RW_WR_MAX, hold_cnt));
                a = pick_addr(hold_base, hold_cnt, n);
                q = {q, ra[15:8], ra[7:0], rn[15:8], rn[7:0],
                     a[15:8], a[7:0], n[15:8], n[7:0], 8'(2 * n)};
                repeat (2 * n) q.push_back(8'($urandom));
                plen = 2 + 2 * rn;
            end
            default: repeat ($urandom_range(0, 6)) q.push_back(8'($urandom));
        endcase
        if (broken)
        begin
            case ($urandom_range(0, 2))
                0: if (q.size() > 1) void'(q.pop_back());
                1: q.push_back(8'($urandom));
                default:
                    if (q.size() > 4)
                    begin
                        q[3] = 8'($urandom);
                        q[4] = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom);
                    end
            endcase
        end
        push_pdu(q);
        // pull all of it, one too many, or leave it part pulled
        if ($urandom_range(0, 5) == 0)
            push_pulls($urandom_range(0, plen));
        else
            push_pulls(plen + ($urandom_range(0, 3) == 0));
    endfunction

    function automatic void gen_random();
        int unsigned r;
        logic [7:0] fcs[5];
        fcs = '{FC_RD_HOLD, FC_RD_INPUT, FC_WR_ONE, FC_WR_MULTI, FC_RW_MULTI};
        r = $urandom_range(0, 99);
        if (r < 12)
            push_item(OP_LOAD, 8'($urandom), 1'($urandom), 8'($urandom), 16'($urandom));
        else if (r < 18)
            gen_request(8'($urandom), $urandom_range(0, 1) == 1);
        else if (r < 21)
            push_item(OP_IGNORED, 8'($urandom), 1'($urandom), 8'($urandom),
                      16'($urandom));
        else if (r < 26)
            push_pulls($urandom_range(1, 4));
        else
            gen_request(fcs[$urandom_range(0, 4)], $urandom_range(0, 7) == 0);
    endfunction

    // ---------------- configuration and phase control ----------------
    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_HOLD_BASE:  hold_base = 32'(data);
            REG_HOLD_COUNT: hold_cnt  = 32'(data[8:0]);
            REG_IN_BASE:    in_base   = 32'(data);
            default:        in_cnt    = 32'(data[8:0]);
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (item_q.size() > 0 || in_valid || resp_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(int unsigned hb, int unsigned hc, int unsigned ib,
                             int unsigned ic);
        int unsigned goal;
        write_reg(REG_HOLD_BASE, 16'(hb));
        write_reg(REG_HOLD_COUNT, 16'(hc));
        write_reg(REG_IN_BASE, 16'(ib));
        write_reg(REG_IN_COUNT, 16'(ic));
        goal = pushed + PHASE_ITEMS;
        while (pushed < goal)
            gen_random();
        drain();
    endtask

    initial
    begin
        logic [7:0] q[$];
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset window: every register access by a request is out of range
        push_pulls(1);
        gen_request(FC_RD_HOLD, 1'b0);
        repeat (10) gen_random();
        drain();

        // directed: extremes, every function, exception paths
        write_reg(REG_HOLD_BASE, 16'd0);
        write_reg(REG_HOLD_COUNT, 16'd256);
        write_reg(REG_IN_BASE, 16'd0);
        write_reg(REG_IN_COUNT, 16'd256);
        push_item(OP_LOAD, 8'h00, 1'b0, 8'h00, 16'hFFFF);
        push_item(OP_LOAD, 8'hFF, 1'b1, 8'hFF, 16'h0000);
        push_item(OP_IGNORED, 8'hFF, 1'b1, 8'hFF, 16'hFFFF);
        push_pdu({FC_RD_INPUT, 8'h00, 8'hFF, 8'h00, 8'h01});
        push_pulls(5);
        push_pdu({FC_WR_ONE, 8'h00, 8'hFF, 8'hFF, 8'hFF});
        push_pulls(5);
        push_pdu({FC_RD_HOLD, 8'h00, 8'h00, 8'h00, 8'd125});
        push_pulls(2);
        push_pdu({8'hFF});
        push_pulls(3);
        push_pdu({FC_RD_HOLD, 8'h00, 8'h00, 8'h00});
        push_pulls(2);
        gen_request(FC_WR_MULTI, 1'b0);
        gen_request(FC_RW_MULTI, 1'b0);
        // request longer than the buffer: tail bytes are dropped
        q = {FC_RD_HOLD};
        repeat (259) q.push_back(8'($urandom));
        push_pdu(q);
        push_pulls(2);
        drain();

        run_phase(0, 256, 0, 256);
        run_phase(1000, 40, 65535, 1);
        run_phase(65535, 1, 300, 256);
        run_phase(65400, 256, 12345, 100);
        run_phase(200, 0, 65280, 256);
        quiet = 1;
        run_phase(32768, 200, 0, 0);

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // ---------------- input driver ----------------
    always @(posedge clk or negedge rst_n)
    begin
        logic next_valid;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            next_valid = in_valid;
            // record the transfer, then load the next pending item
            if (in_valid && in_ready)
            begin
                predict_item(cur_item);
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (in_gap > 0)
                    in_gap--;
                else if (item_q.size() > 0)
                begin
                    cur_item = item_q.pop_front();
                    op         <= cur_item.op;
                    pdu_byte   <= cur_item.pbyte;
                    pdu_last   <= cur_item.plast;
                    load_index <= cur_item.lidx;
                    load_value <= cur_item.lval;
                    next_valid = 1'b1;
                    if (!quiet && $urandom_range(0, 5) == 0)
                        in_gap = $urandom_range(1, 16);
                end
            end
            in_valid <= next_valid;
        end
    end

    // ---------------- output backpressure ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b1;
        else if (out_stall > 0)
        begin
            out_stall--;
            out_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            out_stall = $urandom_range(0, 15);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // ---------------- result checker ----------------
    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        resp_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (resp_q.size() == 0)
            begin
                $display("%0t: unexpected result expected none actual status %0h len %0d",
                         $time, status, resp_length);
                errors++;
            end
            else
            begin
                e = resp_q.pop_front();
                check_field("status", e.st, status);
                check_field("resp_length", e.len, resp_length);
                check_field("resp_byte", e.rbyte, resp_byte);
                check_field("resp_last", e.rlast, resp_last);
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

endmodule

### sim.f
hdl/mbrs_pkg.sv
hdl/mbrs_ctrl.sv
hdl/mbrs_dp.sv
hdl/modbus_register_server.sv
hdl/mbrs_checker.sv
verif/tb_top.sv
